### design/ppe_pkg.sv
// ppe_pkg: shared widths, register indexes and the result record
// for the pwm pattern expander; no dependencies
package ppe_pkg;

  localparam int DUR_W    = 16;
  localparam int INTEN_W  = 8;
  localparam int TIME_W   = 16;
  localparam int PERIOD_W = 10;
  localparam int STEP_W   = 7;
  localparam int CFG_IDX_W = 1;

  // intensity at or above this is full on
  localparam logic [INTEN_W-1:0] FULL_INTEN = 8'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_STEP      = 1'b1;

  // power-on register values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd40;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 7'd4;

  typedef struct packed {
    logic              has_segment;
    logic [TIME_W-1:0] segment_time;
    logic              is_off_phase;
    logic              pattern_full;
    logic              last;
  } result_t;

endpackage

### design/ppe_step_unit.sv
// ppe_step_unit: the shared subtract-and-compare unit that peels one
// pwm period off the remaining duration; uses ppe_pkg
module ppe_step_unit (
  input  logic [ppe_pkg::DUR_W-1:0]    operand,
  input  logic [ppe_pkg::PERIOD_W-1:0] period,
  output logic [ppe_pkg::DUR_W-1:0]    diff,
  output logic                         ge
);
  import ppe_pkg::*;

  logic [DUR_W:0] wide_diff;

  // borrow out of the subtraction means operand < period
  assign wide_diff = {1'b0, operand} - {1'b0, DUR_W'(period)};
  assign diff      = wide_diff[DUR_W-1:0];
  assign ge        = ~wide_diff[DUR_W];

endmodule

### design/ppe_out_reg.sv
// ppe_out_reg: output register that holds one result until the
// downstream side takes it; uses ppe_pkg
module ppe_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ppe_pkg::result_t din,
  input  logic             ready,
  output logic             valid,
  output ppe_pkg::result_t dout,
  output logic             free
);
  import ppe_pkg::*;

  // slot can take a new result when empty or being drained this cycle
  assign free = ~valid | ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      dout <= din;
    end
  end

endmodule

### design/pwm_pattern_expander.sv
// pwm_pattern_expander: top level, sequencer, configuration registers
// and segment count; uses ppe_pkg, ppe_step_unit, ppe_out_reg
//
// Turns one (duration, intensity) segment per input transfer into a run of
// on/off millisecond times appended to a pattern of at most CAPACITY times.
// A pause gives (0, duration), full strength (intensity 10 or more) gives
// (duration, 0), and intensities 1 to 9 give one (on, period - on) pair per
// whole pwm period in the duration, with on = min(intensity * on_step,
// period). Pairs are appended only while two more fit. Each appended time
// leaves as one output transfer, on time first; a segment that appends
// nothing yields a single status transfer with has_segment low. m_tlast
// marks the final transfer of each segment and pattern_full reports a full
// pattern. A segment gives 1 to CAPACITY output transfers. It passes an
// accept step, a setup step for the on-time product and the first period
// compare, then one state per result that holds while the output stalls.
// Each further pulse reuses the single subtract-and-compare unit to take
// one period off the remaining duration. s_tready is high only while no
// segment is in work. Configuration writes take effect at the edge where
// cfg_we is high.
module pwm_pattern_expander #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // input segments
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // duration [15:0], intensity [23:16]
  input  logic                            s_tuser,  // start_pattern
  // emitted times
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,  // segment_time [15:0]
  output logic [2:0]                      m_tuser,  // pattern_full [2], is_off_phase [1], has_segment [0]
  output logic                            m_tlast,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppe_pkg::PERIOD_W-1:0]    cfg_data
);
  import ppe_pkg::*;

  // count must reach CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W:0]   CAP_X = (CNT_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ON,
    ST_OFF,
    ST_STATUS
  } state_t;

  state_t state;

  // configuration registers
  logic [PERIOD_W-1:0] pulse_period;
  logic [STEP_W-1:0]   on_step;

  // segment in work
  logic [CNT_W-1:0]   segment_count;
  logic [DUR_W-1:0]   dur_q;
  logic [INTEN_W-1:0] inten_q;
  logic [DUR_W-1:0]   rem;
  logic [TIME_W-1:0]  on_time;
  logic [TIME_W-1:0]  rest_time;
  logic               single;

  // shared unit
  logic [DUR_W-1:0] sub_a;
  logic [DUR_W-1:0] sub_diff;
  logic             sub_ge;

  // pwm on/off times, only looked at in setup
  logic [PERIOD_W+STEP_W-6:0] prod;
  logic [PERIOD_W-1:0]        on_pwm;
  logic [PERIOD_W-1:0]        off_pwm;

  logic [CNT_W-1:0] cnt_inc;
  logic             room_now;
  logic             room_after;
  logic             more;

  // output side
  result_t res;
  result_t out_res;
  logic    out_load;
  logic    out_free;

  assign s_tready = (state == ST_IDLE);

  // setup compares the whole duration, later steps the remainder
  assign sub_a = (state == ST_SETUP) ? dur_q : rem;

  ppe_step_unit u_step (
    .operand (sub_a),
    .period  (pulse_period),
    .diff    (sub_diff),
    .ge      (sub_ge)
  );

  // intensity 1..9 fits four bits
  assign prod    = (PERIOD_W + STEP_W - 5)'(inten_q[3:0]) * (PERIOD_W + STEP_W - 5)'(on_step);
  assign on_pwm  = (prod > (PERIOD_W + STEP_W - 5)'(pulse_period)) ? pulse_period
                                                                   : prod[PERIOD_W-1:0];
  assign off_pwm = pulse_period - on_pwm;

  assign cnt_inc    = segment_count + CNT_W'(1);
  assign room_now   = ({1'b0, segment_count} + (CNT_W + 1)'(2)) <= CAP_X;
  assign room_after = ({1'b0, cnt_inc} + (CNT_W + 1)'(2)) <= CAP_X;
  // another pair follows this off time
  assign more       = ~single & sub_ge & room_after;

  always_comb begin
    res      = '0;
    out_load = 1'b0;
    unique case (state)
      ST_ON: begin
        out_load         = 1'b1;
        res.has_segment  = 1'b1;
        res.segment_time = on_time;
        res.pattern_full = (cnt_inc == CAP_C);
      end
      ST_OFF: begin
        out_load         = 1'b1;
        res.has_segment  = 1'b1;
        res.segment_time = rest_time;
        res.is_off_phase = 1'b1;
        res.pattern_full = (cnt_inc == CAP_C);
        res.last         = ~more;
      end
      ST_STATUS: begin
        out_load         = 1'b1;
        res.pattern_full = (segment_count == CAP_C);
        res.last         = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  ppe_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .din   (res),
    .ready (m_tready),
    .valid (m_tvalid),
    .dout  (out_res),
    .free  (out_free)
  );

  assign m_tdata = out_res.segment_time;
  assign m_tuser = {out_res.pattern_full, out_res.is_off_phase, out_res.has_segment};
  assign m_tlast = out_res.last;

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      segment_count <= '0;
      pulse_period  <= PERIOD_RESET;
      on_step       <= STEP_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PULSE_PERIOD: pulse_period <= cfg_data;
          CFG_ON_STEP:      on_step      <= cfg_data[STEP_W-1:0];
          default:          pulse_period <= pulse_period;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            dur_q   <= s_tdata[DUR_W-1:0];
            inten_q <= s_tdata[DUR_W+INTEN_W-1:DUR_W];
            if (s_tuser) begin
              segment_count <= '0;
            end
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (dur_q == '0 || !room_now) begin
            state <= ST_STATUS;
          end else if (inten_q == '0) begin
            on_time   <= '0;
            rest_time <= dur_q;
            single    <= 1'b1;
            state     <= ST_ON;
          end else if (inten_q >= FULL_INTEN) begin
            on_time   <= dur_q;
            rest_time <= '0;
            single    <= 1'b1;
            state     <= ST_ON;
          end else if (pulse_period == '0 || !sub_ge) begin
            // no whole period in the duration
            state <= ST_STATUS;
          end else begin
            rem       <= sub_diff;
            on_time   <= TIME_W'(on_pwm);
            rest_time <= TIME_W'(off_pwm);
            single    <= 1'b0;
            state     <= ST_ON;
          end
        end
        ST_ON: begin
          if (out_free) begin
            segment_count <= cnt_inc;
            state         <= ST_OFF;
          end
        end
        ST_OFF: begin
          if (out_free) begin
            segment_count <= cnt_inc;
            if (more) begin
              rem   <= sub_diff;
              state <= ST_ON;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/ppe_checker.sv
// ppe_checker: port-level checks on the pwm pattern expander, bound
// to the top level; no package dependency
module ppe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled output transfer changed");

  // one segment at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while a segment is in work");

  // a status result is alone and empty
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 16'd0) && !m_tuser[1])
    else $error("status result malformed");

  // an on time is always followed by its off time
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && !m_tuser[1] |-> !m_tlast && !m_tuser[2])
    else $error("on time ended a segment or filled the pattern");

  // filling the pattern ends the segment
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && m_tuser[2] |-> m_tuser[1] && m_tlast)
    else $error("pattern full but segment continues");

endmodule

bind pwm_pattern_expander ppe_checker u_ppe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for pwm_pattern_expander; segments go in on the input
// stream, every emitted on/off time is predicted here and checked on the output stream
// depends on ppe_pkg and the design sources under design/
module tb_top;
  import ppe_pkg::*;

  localparam int CAP         = 64;    // pattern capacity given to the block
  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int LONG_HOLD   = 500;   // receiver hold-off that backs up the input

  // one input segment as the bench sees it
  typedef struct packed {
    logic               start;
    logic [DUR_W-1:0]   dur;
    logic [INTEN_W-1:0] inten;
  } seg_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [23:0]         s_tdata   = '0;   // duration [15:0], intensity [23:16]
  logic                s_tuser   = 1'b0; // start_pattern
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [15:0]         m_tdata;          // segment_time [15:0]
  logic [2:0]          m_tuser;          // pattern_full [2], is_off_phase [1], has_segment [0]
  logic                m_tlast;
  logic                cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PULSE_PERIOD;
  logic [PERIOD_W-1:0] cfg_data  = '0;

  pwm_pattern_expander #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // bench copy of the registers and of the pattern length
  logic [PERIOD_W-1:0] model_period = PERIOD_RESET;
  logic [STEP_W-1:0]   model_step   = STEP_RESET;
  int unsigned         pat_count    = 0;

  result_t     times_due[$];     // expected output transfers, oldest first
  seg_t        segs_to_send[$];  // segments waiting for the driver
  seg_t        seg_on_bus;       // segment currently offered on the input
  result_t     due_now;

  int unsigned n_queued  = 0;
  int unsigned n_taken   = 0;
  int unsigned n_results = 0;
  int unsigned n_full    = 0;
  int unsigned n_errors  = 0;
  int unsigned n_phases  = 0;
  int unsigned send_gap  = 0;
  int unsigned stall_left = 0;
  int unsigned quiet     = 0;
  int          hold_req  = 0;
  int          hold_ack  = 0;
  bit          calm      = 1'b0;  // no idling on either side while set

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic seg_t seg_of(input logic start, input int unsigned dur,
                                  input int unsigned inten);
    seg_t sg;
    sg.start = start;
    sg.dur   = dur[DUR_W-1:0];
    sg.inten = inten[INTEN_W-1:0];
    return sg;
  endfunction

  // random segment; durations lean toward a few periods so pwm pulses show up
  function automatic seg_t make_segment(input logic start);
    seg_t        sg;
    int unsigned r;
    int unsigned d;
    sg.start = start;
    r = $urandom_range(0, 99);
    if (r < 10)      d = 0;
    else if (r < 18) d = 65535;
    else if (r < 38) d = $urandom_range(0, 65535);
    else if (r < 50) d = $urandom_range(1, 255);
    else             d = model_period * $urandom_range(0, 4) + $urandom_range(0, model_period);
    if (d > 65535) d = 65535;
    sg.dur = d[DUR_W-1:0];
    r = $urandom_range(0, 99);
    if (r < 25)      sg.inten = '0;
    else if (r < 65) sg.inten = INTEN_W'($urandom_range(1, 9));
    else if (r < 85) sg.inten = INTEN_W'($urandom_range(10, 255));
    else             sg.inten = INTEN_W'($urandom_range(0, 255));
    return sg;
  endfunction

  task automatic queue_segment(input seg_t sg);
    segs_to_send.push_back(sg);
    n_queued++;
  endtask

  // one appended time: the count grows first, fullness is seen after the append
  task automatic append_time(input logic [TIME_W-1:0] t, input logic off);
    result_t r;
    pat_count++;
    r.has_segment  = 1'b1;
    r.segment_time = t;
    r.is_off_phase = off;
    r.pattern_full = (pat_count == CAP);
    r.last         = 1'b0;
    times_due.push_back(r);
  endtask

  // expected output transfers for one accepted segment
  task automatic expand_segment(input seg_t sg);
    int unsigned due_mark;
    int unsigned n_pulse;
    int unsigned on_t;
    int unsigned i;
    result_t     r;
    due_mark = times_due.size();
    if (sg.start) pat_count = 0;
    if (sg.dur != 0 && pat_count + 2 <= CAP) begin
      if (sg.inten == 0) begin
        // pause: nothing on, whole duration off
        append_time('0, 1'b0);
        append_time(sg.dur, 1'b1);
      end else if (sg.inten >= FULL_INTEN) begin
        append_time(sg.dur, 1'b0);
        append_time('0, 1'b1);
      end else if (model_period != 0) begin
        // one pair per whole period, on time clamped so off never wraps
        n_pulse = int'(sg.dur) / int'(model_period);
        on_t    = int'(sg.inten) * int'(model_step);
        if (on_t > model_period) on_t = model_period;
        for (i = 0; i < n_pulse && pat_count + 2 <= CAP; i++) begin
          append_time(on_t[TIME_W-1:0], 1'b0);
          append_time(TIME_W'(int'(model_period) - on_t), 1'b1);
        end
      end
    end
    if (times_due.size() == due_mark) begin
      // nothing appended: a single status transfer
      r = '0;
      r.pattern_full = (pat_count == CAP);
      r.last         = 1'b1;
      times_due.push_back(r);
    end else begin
      r = times_due.pop_back();
      r.last = 1'b1;
      times_due.push_back(r);
    end
  endtask

  // wait until every segment is taken and every time has come out
  task automatic settle();
    while (n_taken != n_queued || times_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both registers, one per cycle, and track them in the bench copy
  task automatic set_config(input int unsigned period, input int unsigned step);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PULSE_PERIOD;
    cfg_data  <= period[PERIOD_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_ON_STEP;
    cfg_data  <= step[PERIOD_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_period = period[PERIOD_W-1:0];
    model_step   = step[STEP_W-1:0];
    n_phases++;
  endtask

  // mostly whole patterns (a start segment and a few follow-ups), some stray segments
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned j;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_segment(make_segment(1'($urandom_range(0, 1))));
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) queue_segment(make_segment(j == 0));
        sent += len;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // input driver: predicts on each accepted transfer, then offers the next segment
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        n_taken++;
        expand_segment(seg_on_bus);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (segs_to_send.size() > 0) begin
          seg_on_bus = segs_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {seg_on_bus.inten, seg_on_bus.dur};
          s_tuser  <= seg_on_bus.start;
          send_gap = calm ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each result transfer and throttles m_tready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (m_tuser[2]) n_full++;
        if (times_due.size() == 0) begin
          $error("result transfer with nothing expected, segment_time %0d", m_tdata);
          n_errors++;
        end else begin
          due_now = times_due.pop_front();
          check_field("has_segment", due_now.has_segment, m_tuser[0]);
          check_field("segment_time", due_now.segment_time, m_tdata);
          check_field("is_off_phase", due_now.is_off_phase, m_tuser[1]);
          check_field("pattern_full", due_now.pattern_full, m_tuser[2]);
          check_field("last", due_now.last, m_tlast);
        end
      end
      // a long hold-off asked for by the stimulus so the block backs up
      if (hold_ack != hold_req) begin
        hold_ack   = hold_req;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  // watchdog: too long without any transfer means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned ph;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset register values: 40 ms period, 4 ms per intensity unit
    queue_segment(seg_of(1, 0, 5));       // zero duration
    queue_segment(seg_of(0, 100, 0));     // pause
    queue_segment(seg_of(0, 65535, 255)); // full on, widest fields
    queue_segment(seg_of(0, 300, 10));    // lowest full-on intensity
    queue_segment(seg_of(0, 120, 9));     // three pwm pulses
    queue_segment(seg_of(0, 39, 1));      // shorter than one period
    queue_segment(seg_of(0, 80, 1));
    queue_segment(seg_of(1, 65535, 5));   // many pulses, runs into capacity
    queue_segment(seg_of(0, 10, 0));      // pattern already full
    queue_segment(seg_of(0, 0, 10));      // zero duration while full
    queue_segment(seg_of(1, 1, 3));       // start clears, still too short
    queue_segment(seg_of(0, 40, 9));      // exactly one period
    settle();

    // on time above the period is clamped, off time goes to zero
    set_config(10, 127);
    queue_segment(seg_of(1, 30, 1));
    queue_segment(seg_of(0, 25, 9));
    queue_segment(seg_of(0, 65535, 128));
    settle();

    // zero period: pwm appends nothing, pause and full on as usual
    set_config(0, 102);
    queue_segment(seg_of(1, 500, 5));
    queue_segment(seg_of(0, 500, 0));
    queue_segment(seg_of(0, 7, 200));
    queue_segment(seg_of(0, 65535, 9));
    settle();

    // random phases, register extremes first
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(1023, 127);
        1: set_config(1, 0);
        2: set_config(0, $urandom_range(0, 127));
        default: set_config($urandom_range(2, 300), $urandom_range(0, 40));
      endcase
      calm = (ph == 3);
      run_random_phase(42);
      if (ph == 4) hold_req++;
      settle();
    end
    calm = 1'b0;
    repeat (30) @(posedge clk);

    $display("segments sent: %0d over %0d register settings", n_taken, n_phases + 1);
    $display("result transfers checked: %0d, with pattern full: %0d", n_results, n_full);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### pwm_pattern_expander.f
design/ppe_pkg.sv
design/ppe_step_unit.sv
design/ppe_out_reg.sv
design/pwm_pattern_expander.sv
design/ppe_checker.sv
tb/sv/tb_top.sv
